### design/ille_pkg.sv
`timescale 1ns / 1ps

package ille_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FINISH,
        S_INS2,
        S_DEL2,
        S_LOADV,
        S_RESP
    } state_t;

endpackage

### design/ille_if.sv
`timescale 1ns / 1ps

interface ille_in_if import ille_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

interface ille_out_if import ille_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

### design/indexed_linked_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values kept in CAPACITY linked slots.
// The input channel in_ch carries one command per transaction: insert,
// read or delete at a zero-based position. The output channel out_ch
// returns exactly one result transaction per command: the value read (-1
// on a failed read, 0 for other commands), a status and the new length.
// One command is handled at a time: in_ch.ready is high only while the
// block is idle, and it rises again in the cycle after the result is taken.
// A command that fails its checks goes from S_DECODE straight to S_RESP,
// where out_ch.valid is raised. Otherwise the sequencer follows one link per
// cycle from the head through a single read port of the link memory, in
// S_WALK; a read then passes S_FINISH and S_LOADV, and an insert or a
// delete passes S_FINISH and, for a middle position, S_INS2 or S_DEL2,
// before reaching S_RESP.
// Reset empties the list and marks every slot free; the slot memories
// themselves are not cleared, so the block is ready at once after reset.
// While out_ch.ready is low the result is held stable and no new command
// is accepted.

module indexed_linked_list_engine import ille_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ille_in_if.sink     in_ch,
    ille_out_if.source  out_ch
);

    localparam int SW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

    state_t state_reg, state_next;

    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] stk_top_reg, stk_top_next;

    cmd_t                      cmd_reg, cmd_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [SW-1:0]             cur_reg, cur_next;
    logic [CW-1:0]             hops_reg, hops_next;
    logic [SW-1:0]             slot_reg, slot_next;
    logic [SW-1:0]             victim_reg, victim_next;
    logic signed [VALUE_W-1:0] rv_reg, rv_next;
    status_t                   st_reg, st_next;

    logic                      link_we;
    logic [SW-1:0]             link_waddr, link_wdata, link_raddr, link_q;
    logic                      value_we;
    logic [SW-1:0]             value_waddr;
    logic signed [VALUE_W-1:0] value_q;
    logic                      stk_we;
    logic [SW-1:0]             stk_wdata, stk_raddr, stk_q;

    logic [CW-1:0]             pos_ext, len_ext;
    logic                      len_full, ins_mid, del_mid, cmd_fail;
    status_t                   dec_status;
    logic signed [VALUE_W-1:0] dec_rv;
    logic [CW-1:0]             dec_hops;
    logic [SW-1:0]             alloc_slot;

    ille_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_W)) u_values (
        .clk   (clk),
        .we    (value_we),
        .waddr (value_waddr),
        .wdata (val_reg),
        .raddr (cur_reg),
        .rdata (value_q)
    );

    ille_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    // Stack of recycled slots; slots never used yet come from fresh_reg.
    ille_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_top_reg[SW-1:0]),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    assign pos_ext    = CW'(pos_reg);
    assign len_ext    = CW'(len_reg);
    assign len_full   = (len_reg == LW'(CAPACITY));
    assign ins_mid    = (len_reg != '0) && (pos_ext != '0) && (pos_ext != len_ext);
    assign del_mid    = (pos_ext != '0) && (pos_ext != len_ext - CW'(1));
    assign stk_raddr  = SW'(stk_top_reg - LW'(1));
    assign alloc_slot = (stk_top_reg != '0) ? stk_q : fresh_reg[SW-1:0];
    assign cmd_fail   = (dec_status != ST_OK);

    // Checks and walk length for the latched command.
    always_comb
    begin
        dec_status = ST_OK;
        dec_rv     = '0;
        dec_hops   = '0;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (pos_ext > len_ext)
                    dec_status = ST_BAD_POS;
                else if (len_full)
                    dec_status = ST_FULL;
                else if (ins_mid)
                    dec_hops = pos_ext - CW'(1);
            end
            CMD_READ:
            begin
                if (pos_ext >= len_ext)
                begin
                    dec_status = ST_BAD_POS;
                    dec_rv     = '1;
                end
                else
                    dec_hops = pos_ext;
            end
            CMD_DELETE:
            begin
                if (len_reg == '0)
                    dec_status = ST_EMPTY;
                else if (pos_ext >= len_ext)
                    dec_status = ST_BAD_POS;
                else if (pos_ext != '0)
                    dec_hops = pos_ext - CW'(1);
            end
            CMD_NONE:
                dec_status = ST_BAD_POS;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                if (cmd_fail)
                    state_next = S_RESP;
                else if (dec_hops == '0)
                    state_next = S_FINISH;
                else
                    state_next = S_WALK;
            end
            S_WALK:
                if (hops_reg == CW'(1))
                    state_next = S_FINISH;
            S_FINISH:
            begin
                priority if (cmd_reg == CMD_READ)
                    state_next = S_LOADV;
                else if (cmd_reg == CMD_INSERT && ins_mid)
                    state_next = S_INS2;
                else if (cmd_reg == CMD_DELETE && del_mid)
                    state_next = S_DEL2;
                else
                    state_next = S_RESP;
            end
            S_INS2, S_DEL2, S_LOADV:
                state_next = S_RESP;
            S_RESP:
                if (out_ch.ready)
                    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        len_next     = len_reg;
        fresh_next   = fresh_reg;
        stk_top_next = stk_top_reg;
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        cur_next     = cur_reg;
        hops_next    = hops_reg;
        slot_next    = slot_reg;
        victim_next  = victim_reg;
        rv_next      = rv_reg;
        st_next      = st_reg;
        link_we      = 1'b0;
        link_waddr   = cur_reg;
        link_wdata   = link_q;
        link_raddr   = cur_reg;
        value_we     = 1'b0;
        value_waddr  = alloc_slot;
        stk_we       = 1'b0;
        stk_wdata    = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next = cmd_t'(in_ch.command);
                    pos_next = in_ch.position;
                    val_next = in_ch.item_value;
                end
            end
            S_DECODE:
            begin
                link_raddr = head_reg;
                cur_next   = head_reg;
                hops_next  = dec_hops;
                st_next    = dec_status;
                rv_next    = dec_rv;
            end
            S_WALK:
            begin
                // link_q holds the link of cur_reg; follow it and fetch the next one.
                link_raddr = link_q;
                cur_next   = link_q;
                hops_next  = hops_reg - CW'(1);
            end
            S_FINISH:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    slot_next = alloc_slot;
                    value_we  = 1'b1;
                    if (len_reg == '0)
                    begin
                        head_next = alloc_slot;
                        tail_next = alloc_slot;
                    end
                    else if (pos_ext == '0)
                    begin
                        link_we    = 1'b1;
                        link_waddr = alloc_slot;
                        link_wdata = head_reg;
                        head_next  = alloc_slot;
                    end
                    else if (pos_ext == len_ext)
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_reg;
                        link_wdata = alloc_slot;
                        tail_next  = alloc_slot;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = alloc_slot;
                        link_wdata = link_q;
                    end
                    if (stk_top_reg != '0)
                        stk_top_next = stk_top_reg - LW'(1);
                    else
                        fresh_next = fresh_reg + LW'(1);
                    len_next = len_reg + LW'(1);
                end
                else if (cmd_reg == CMD_DELETE)
                begin
                    len_next = len_reg - LW'(1);
                    if (pos_ext == '0)
                    begin
                        if (len_reg == LW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                            head_next = link_q;
                        stk_we       = 1'b1;
                        stk_wdata    = cur_reg;
                        stk_top_next = stk_top_reg + LW'(1);
                    end
                    else if (!del_mid)
                    begin
                        tail_next    = cur_reg;
                        stk_we       = 1'b1;
                        stk_wdata    = link_q;
                        stk_top_next = stk_top_reg + LW'(1);
                    end
                    else
                    begin
                        // Fetch the victim's link so that it can be spliced out.
                        victim_next = link_q;
                        link_raddr  = link_q;
                    end
                end
            end
            S_INS2:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
            end
            S_DEL2:
            begin
                link_we      = 1'b1;
                link_waddr   = cur_reg;
                link_wdata   = link_q;
                stk_we       = 1'b1;
                stk_wdata    = victim_reg;
                stk_top_next = stk_top_reg + LW'(1);
            end
            S_LOADV:
                rv_next = value_q;
            S_RESP:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            len_reg     <= '0;
            fresh_reg   <= '0;
            stk_top_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            len_reg     <= len_next;
            fresh_reg   <= fresh_next;
            stk_top_reg <= stk_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        hops_reg   <= hops_next;
        slot_reg   <= slot_next;
        victim_reg <= victim_next;
        rv_reg     <= rv_next;
        st_reg     <= st_next;
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_RESP);
    assign out_ch.read_value  = rv_reg;
    assign out_ch.status      = st_reg;
    assign out_ch.entry_count = len_ext[COUNT_W-1:0];

endmodule

### design/ille_ram.sv
`timescale 1ns / 1ps

module ille_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/ille_checker.sv
`timescale 1ns / 1ps

module ille_checker import ille_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] read_value,
    input logic [STATUS_W-1:0]       status,
    input logic [COUNT_W-1:0]        entry_count
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // Only one command is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted a second transaction while busy");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value)
            && $stable(status) && $stable(entry_count))
        else $error("stalled result transaction changed");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == FULL_COUNT)
        else $error("store full reported with list not at capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entry_count == '0)
        else $error("list empty reported with entries present");

endmodule

bind indexed_linked_list_engine ille_checker #(.CAPACITY(CAPACITY)) u_ille_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .read_value  (out_ch.read_value),
    .status      (out_ch.status),
    .entry_count (out_ch.entry_count)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import ille_pkg::*; ();

    localparam int CAPACITY    = 64;
    localparam int RANDOM_CMDS = 650;
    localparam int CALM_TAIL   = 60;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        cmd_t                      cmd;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } list_cmd_t;

    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
    } list_result_t;

    logic clk;
    logic rst_n;

    ille_in_if  in_ch();
    ille_out_if out_ch();

    indexed_linked_list_engine #(.CAPACITY(CAPACITY)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Contents of the list as the block should hold them, head first.
    logic signed [VALUE_W-1:0] list_contents[$];
    list_result_t              expected_results[$];
    list_cmd_t                 pending_cmds[$];

    int  plan_len;
    int  cmds_queued;
    int  cmds_sent;
    int  cmds_accepted;
    int  results_seen;
    int  err_count;
    int  calm_from;
    int  peak_len;
    int  status_tally[4];
    int  cycle_count;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    bit  long_hold_done;
    logic in_fire;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_result_t list_apply(cmd_t cmd, logic [POS_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] value);
        list_result_t r;
        int           idx;
        idx          = int'(pos);
        r.read_value = '0;
        r.status     = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (idx > list_contents.size())
                    r.status = ST_BAD_POS;
                else if (list_contents.size() == CAPACITY)
                    r.status = ST_FULL;
                else if (idx == list_contents.size())
                    list_contents.push_back(value);
                else
                    list_contents.insert(idx, value);
            end
            CMD_READ:
            begin
                if (idx >= list_contents.size())
                begin
                    r.status     = ST_BAD_POS;
                    r.read_value = -1;
                end
                else
                    r.read_value = list_contents[idx];
            end
            CMD_DELETE:
            begin
                if (list_contents.size() == 0)
                    r.status = ST_EMPTY;
                else if (idx >= list_contents.size())
                    r.status = ST_BAD_POS;
                else
                    list_contents.delete(idx);
            end
            default:
                r.status = ST_BAD_POS;
        endcase
        r.entry_count = COUNT_W'(list_contents.size());
        if (list_contents.size() > peak_len)
            peak_len = list_contents.size();
        return r;
    endfunction

    // The stimulus side tracks only the length, so that positions can be aimed.
    function automatic void queue_cmd(cmd_t cmd, int pos, logic signed [VALUE_W-1:0] value);
        list_cmd_t c;
        c.cmd   = cmd;
        c.pos   = POS_W'(pos);
        c.value = value;
        pending_cmds.push_back(c);
        cmds_queued++;
        if (cmd == CMD_INSERT && pos <= plan_len && plan_len < CAPACITY)
            plan_len++;
        else if (cmd == CMD_DELETE && plan_len > 0 && pos < plan_len)
            plan_len--;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos(int limit);
        int k;
        k = $urandom_range(0, 99);
        if (limit < 0)
            return $urandom_range(0, 127);
        if (k < 8)
            return $urandom_range(127, limit + 1);
        if (k < 20)
            return 0;
        if (k < 32)
            return limit;
        return $urandom_range(0, limit);
    endfunction

    function automatic void random_cmd(int ins_w, int rd_w, int del_w);
        int   r;
        cmd_t cmd;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            cmd = CMD_INSERT;
        else if (r < ins_w + rd_w)
            cmd = CMD_READ;
        else if (r < ins_w + rd_w + del_w)
            cmd = CMD_DELETE;
        else
            cmd = CMD_NONE;
        queue_cmd(cmd, pick_pos(cmd == CMD_INSERT ? plan_len : plan_len - 1), pick_value());
    endfunction

    // Driver: a new transaction is offered only once the previous one has gone.
    always @(negedge clk)
    begin
        list_cmd_t c;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                in_ch.valid <= 1'b0;
            else if (cmds_sent < calm_from && $urandom_range(0, 9) == 0)
            begin
                gap_left = $urandom_range(0, 8);
                in_ch.valid <= 1'b0;
            end
            else
            begin
                c = pending_cmds.pop_front();
                in_ch.command    <= c.cmd;
                in_ch.position   <= c.pos;
                in_ch.item_value <= c.value;
                in_ch.valid      <= 1'b1;
                cmds_sent++;
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off once 150 results have been seen.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 150)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (results_seen < calm_from && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Monitor: predicts on each accepted command and checks each accepted result.
    always @(posedge clk)
    begin
        list_result_t want;
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(list_apply(cmd_t'(in_ch.command), in_ch.position,
                                                      in_ch.item_value));
                cmds_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_tally[want.status]++;
                    if (out_ch.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d", want.read_value,
                               out_ch.read_value);
                        err_count++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        err_count++;
                    end
                    if (out_ch.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               out_ch.entry_count);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_NONE;
        in_ch.position   = '0;
        in_ch.item_value = '0;
        out_ch.ready     = 1'b0;
        in_fire          = 1'b0;
        calm_from        = 1 << 30;
        rst_n            = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list, then a single element taken out again.
        queue_cmd(CMD_READ,   0, pick_value());
        queue_cmd(CMD_DELETE, 0, pick_value());
        queue_cmd(CMD_INSERT, 1, pick_value());
        queue_cmd(CMD_INSERT, 0, 32'sh8000_0000);
        queue_cmd(CMD_READ,   0, pick_value());
        queue_cmd(CMD_DELETE, 0, pick_value());
        queue_cmd(CMD_DELETE, 0, pick_value());
        // Build five entries through the tail, the head and the middle.
        queue_cmd(CMD_INSERT, 0, 32'sh7fff_ffff);
        queue_cmd(CMD_INSERT, 1, 32'sh8000_0000);
        queue_cmd(CMD_INSERT, 0, -1);
        queue_cmd(CMD_INSERT, 1, '0);
        queue_cmd(CMD_INSERT, 4, 32'sh1234_5678);
        queue_cmd(CMD_INSERT, 7, pick_value());
        queue_cmd(CMD_READ,   0, pick_value());
        queue_cmd(CMD_READ,   2, pick_value());
        queue_cmd(CMD_READ,   4, pick_value());
        queue_cmd(CMD_READ,   5, pick_value());
        queue_cmd(CMD_READ,   127, pick_value());
        queue_cmd(CMD_NONE,   64, pick_value());
        queue_cmd(CMD_DELETE, 5, pick_value());
        queue_cmd(CMD_DELETE, 2, pick_value());
        queue_cmd(CMD_DELETE, 3, pick_value());
        queue_cmd(CMD_DELETE, 0, pick_value());
        queue_cmd(CMD_READ,   1, pick_value());
        queue_cmd(CMD_INSERT, 64, pick_value());

        // Hold the sender back until every directed result is in.
        while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);

        // Fill to a full store, churn, drain to empty, churn again, and repeat.
        for (int phase = 0; cmds_queued < 25 + RANDOM_CMDS; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    while (plan_len < CAPACITY)
                        random_cmd(75, 15, 8);
                    repeat (4) random_cmd(100, 0, 0);
                end
                2:
                begin
                    while (plan_len > 0)
                        random_cmd(10, 15, 73);
                    repeat (3) random_cmd(0, 0, 100);
                end
                default:
                    repeat (60) random_cmd(40, 30, 28);
            endcase
        end
        calm_from = cmds_queued - CALM_TAIL;

        while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d list commands and checked %0d results; longest list %0d of %0d.",
                 cmds_accepted, results_seen, peak_len, CAPACITY);
        $display("Outcomes: %0d ok, %0d bad position, %0d empty list, %0d store full.",
                 status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_EMPTY],
                 status_tally[ST_FULL]);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
